@@ design/eavt_pkg.sv @@
// Shared types, constants and a helper function of the encoder angle and velocity tracker.
package eavt_pkg;

	localparam int ANG_W = 48;
	localparam int AMAG_W = 36;
	localparam int WRAP_W = 27;
	localparam int VEL_W = 32;
	localparam int MOD_ITERS = 2;
	localparam int NUM_W = 57;
	localparam int QUO_W = 40;
	localparam int STEP_W = 6;

	localparam logic [WRAP_W-1:0] TWO_PI_Q24 = 27'd105414357;
	// floor(2^46 / TWO_PI_Q24), used to estimate the turn count of an angle.
	localparam logic [19:0] MOD_RECIP = 20'd667544;
	localparam logic [13:0] VEL_SCALE = 14'd15625;
	localparam logic [31:0] RATIO_ONE = 32'h0100_0000;
	localparam logic [16:0] ALPHA_ONE = 17'h10000;

	localparam logic [1:0] CFG_INTERVAL = 2'd0;
	localparam logic [1:0] CFG_RATIO = 2'd1;
	localparam logic [1:0] CFG_ALPHA = 2'd2;

	typedef logic [4:0] op_t;
	localparam op_t OP_NONE = 5'd0;
	localparam op_t OP_LOAD = 5'd1;
	localparam op_t OP_CONV_MUL = 5'd2;
	localparam op_t OP_CONV_HI = 5'd3;
	localparam op_t OP_CONV_LO = 5'd4;
	localparam op_t OP_CONV_SUM = 5'd5;
	localparam op_t OP_MOD_INIT = 5'd6;
	localparam op_t OP_MOD_STEP = 5'd7;
	localparam op_t OP_FIRST_OK = 5'd8;
	localparam op_t OP_FIRST_FAIL = 5'd9;
	localparam op_t OP_FAIL = 5'd10;
	localparam op_t OP_ZERO_DT = 5'd11;
	localparam op_t OP_VMUL = 5'd12;
	localparam op_t OP_VSUM = 5'd13;
	localparam op_t OP_DIV_INIT = 5'd14;
	localparam op_t OP_DIV_STEP = 5'd15;
	localparam op_t OP_VSAT = 5'd16;
	localparam op_t OP_EMA_NEW = 5'd17;
	localparam op_t OP_EMA_OLD = 5'd18;
	localparam op_t OP_EMA_SUM = 5'd19;
	localparam op_t OP_COMMIT = 5'd20;
	localparam op_t OP_OUT = 5'd21;

	typedef struct packed {
		op_t op;
		logic [STEP_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic started;
		logic read_ok;
		logic interval_met;
		logic dt_zero;
	} status_t;

	function automatic logic signed [ANG_W-1:0] sat48(input logic signed [ANG_W:0] v);
		logic signed [ANG_W-1:0] r;
		if (v[ANG_W] != v[ANG_W-1]) begin
			r = v[ANG_W] ? {1'b1, {(ANG_W-1){1'b0}}} : {1'b0, {(ANG_W-1){1'b1}}};
		end else begin
			r = v[ANG_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ design/encoder_angle_velocity_tracker.sv @@
// Top level of the encoder angle and velocity tracker: controller plus datapath.
// An ignored item, a failure, zero elapsed time or a failed first read goes from the decision
// straight to output; a good first read adds conversion and reduction, and a tracked update
// adds velocity scaling, the 40-step restoring divider for delta over dt, and filtering.
// One item at a time: the next is accepted the cycle after the previous result is loaded into the
// output register once the output is free. Reset clears state to zero and config to defaults.
module encoder_angle_velocity_tracker #(
	parameter int COUNT_BITS = 14,
	parameter int FAILURE_LIMIT = 5
) (
	input  logic clk,
	input  logic arst_n,
	// Configuration write channel; always ready, index beyond the list is dropped.
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [31:0] cfg_data,
	// Sample item channel.
	input  logic in_valid,
	output logic in_ready,
	input  logic [31:0] timestamp_us,
	input  logic read_ok,
	input  logic [COUNT_BITS-1:0] raw_count,
	// Result item channel.
	output logic out_valid,
	input  logic out_ready,
	output logic updated,
	output logic bus_reinit_request,
	output logic [eavt_pkg::WRAP_W-1:0] wrapped_angle,
	output logic signed [eavt_pkg::ANG_W-1:0] centered_angle,
	output logic signed [eavt_pkg::VEL_W-1:0] velocity
);

	eavt_pkg::cmd_t cmd;
	eavt_pkg::status_t status;

	// Configuration writes land directly in the datapath registers.
	assign cfg_ready = 1'b1;

	// The controller steps through load, conversion, reduction, division and
	// filtering; the datapath performs one operation per command.
	eavt_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.cmd(cmd)
	);

	eavt_dp #(
		.COUNT_BITS(COUNT_BITS),
		.FAILURE_LIMIT(FAILURE_LIMIT)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.timestamp_us(timestamp_us),
		.read_ok(read_ok),
		.raw_count(raw_count),
		.cmd(cmd),
		.status(status),
		.updated(updated),
		.bus_reinit_request(bus_reinit_request),
		.wrapped_angle(wrapped_angle),
		.centered_angle(centered_angle),
		.velocity(velocity)
	);

endmodule

@@ design/eavt_ctrl.sv @@
// Controller state machine that sequences the tracker datapath for one item.
module eavt_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  eavt_pkg::status_t status,
	output eavt_pkg::cmd_t cmd
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_DECIDE = 5'd1;
	localparam logic [4:0] S_CONV_MUL = 5'd2;
	localparam logic [4:0] S_CONV_HI = 5'd3;
	localparam logic [4:0] S_CONV_LO = 5'd4;
	localparam logic [4:0] S_CONV_SUM = 5'd5;
	localparam logic [4:0] S_MOD_INIT = 5'd6;
	localparam logic [4:0] S_MOD_STEP = 5'd7;
	localparam logic [4:0] S_FIRST = 5'd8;
	localparam logic [4:0] S_VMUL = 5'd9;
	localparam logic [4:0] S_VSUM = 5'd10;
	localparam logic [4:0] S_DIV_INIT = 5'd11;
	localparam logic [4:0] S_DIV_STEP = 5'd12;
	localparam logic [4:0] S_VSAT = 5'd13;
	localparam logic [4:0] S_EMA_NEW = 5'd14;
	localparam logic [4:0] S_EMA_OLD = 5'd15;
	localparam logic [4:0] S_EMA_SUM = 5'd16;
	localparam logic [4:0] S_COMMIT = 5'd17;
	localparam logic [4:0] S_OUT = 5'd18;

	localparam logic [eavt_pkg::STEP_W-1:0] MOD_LAST = eavt_pkg::STEP_W'(eavt_pkg::MOD_ITERS - 1);
	localparam logic [eavt_pkg::STEP_W-1:0] DIV_LAST = eavt_pkg::STEP_W'(eavt_pkg::QUO_W - 1);

	logic [4:0] state_q;
	logic [4:0] state_d;
	logic [eavt_pkg::STEP_W-1:0] cnt_q;
	logic [eavt_pkg::STEP_W-1:0] cnt_d;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		cmd.op = eavt_pkg::OP_NONE;
		cmd.step = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = eavt_pkg::OP_LOAD;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (!status.started) begin
					if (status.read_ok) begin
						state_d = S_CONV_MUL;
					end else begin
						cmd.op = eavt_pkg::OP_FIRST_FAIL;
						state_d = S_OUT;
					end
				end else if (!status.interval_met) begin
					state_d = S_OUT;
				end else if (!status.read_ok) begin
					cmd.op = eavt_pkg::OP_FAIL;
					state_d = S_OUT;
				end else if (status.dt_zero) begin
					cmd.op = eavt_pkg::OP_ZERO_DT;
					state_d = S_OUT;
				end else begin
					state_d = S_CONV_MUL;
				end
			end
			S_CONV_MUL: begin
				cmd.op = eavt_pkg::OP_CONV_MUL;
				state_d = S_CONV_HI;
			end
			S_CONV_HI: begin
				cmd.op = eavt_pkg::OP_CONV_HI;
				state_d = S_CONV_LO;
			end
			S_CONV_LO: begin
				cmd.op = eavt_pkg::OP_CONV_LO;
				state_d = S_CONV_SUM;
			end
			S_CONV_SUM: begin
				cmd.op = eavt_pkg::OP_CONV_SUM;
				state_d = S_MOD_INIT;
			end
			S_MOD_INIT: begin
				cmd.op = eavt_pkg::OP_MOD_INIT;
				cnt_d = MOD_LAST;
				state_d = S_MOD_STEP;
			end
			S_MOD_STEP: begin
				cmd.op = eavt_pkg::OP_MOD_STEP;
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					state_d = status.started ? S_VMUL : S_FIRST;
				end
			end
			S_FIRST: begin
				cmd.op = eavt_pkg::OP_FIRST_OK;
				state_d = S_OUT;
			end
			S_VMUL: begin
				cmd.op = eavt_pkg::OP_VMUL;
				state_d = S_VSUM;
			end
			S_VSUM: begin
				cmd.op = eavt_pkg::OP_VSUM;
				state_d = S_DIV_INIT;
			end
			S_DIV_INIT: begin
				cmd.op = eavt_pkg::OP_DIV_INIT;
				cnt_d = DIV_LAST;
				state_d = S_DIV_STEP;
			end
			S_DIV_STEP: begin
				cmd.op = eavt_pkg::OP_DIV_STEP;
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					state_d = S_VSAT;
				end
			end
			S_VSAT: begin
				cmd.op = eavt_pkg::OP_VSAT;
				state_d = S_EMA_NEW;
			end
			S_EMA_NEW: begin
				cmd.op = eavt_pkg::OP_EMA_NEW;
				state_d = S_EMA_OLD;
			end
			S_EMA_OLD: begin
				cmd.op = eavt_pkg::OP_EMA_OLD;
				state_d = S_EMA_SUM;
			end
			S_EMA_SUM: begin
				cmd.op = eavt_pkg::OP_EMA_SUM;
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.op = eavt_pkg::OP_COMMIT;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.op = eavt_pkg::OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ design/eavt_dp.sv @@
// Datapath of the tracker: configuration, tracking state and the arithmetic units.
module eavt_dp #(
	parameter int COUNT_BITS = 14,
	parameter int FAILURE_LIMIT = 5
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic [31:0] timestamp_us,
	input  logic read_ok,
	input  logic [COUNT_BITS-1:0] raw_count,
	input  eavt_pkg::cmd_t cmd,
	output eavt_pkg::status_t status,
	output logic updated,
	output logic bus_reinit_request,
	output logic [eavt_pkg::WRAP_W-1:0] wrapped_angle,
	output logic signed [eavt_pkg::ANG_W-1:0] centered_angle,
	output logic signed [eavt_pkg::VEL_W-1:0] velocity
);

	localparam int AW = eavt_pkg::AMAG_W;
	localparam int WW = eavt_pkg::WRAP_W;
	localparam int GW = eavt_pkg::ANG_W;
	localparam int D_W = COUNT_BITS + 2;
	localparam int P_W = COUNT_BITS + 32;
	localparam int HI_W = COUNT_BITS + 8;
	localparam int M1_W = HI_W + WW;
	localparam int M2_W = 24 + WW;
	localparam int A_W = M1_W + 1;
	localparam int NW = eavt_pkg::NUM_W;
	localparam int QW = eavt_pkg::QUO_W;
	localparam logic [2:0] FAIL_LIM = 3'(FAILURE_LIMIT);
	localparam logic signed [D_W-1:0] HALF = D_W'(1) <<< (COUNT_BITS - 1);
	localparam logic signed [D_W-1:0] FULL = D_W'(1) <<< COUNT_BITS;

	// Configuration registers.
	logic [19:0] interval_q;
	logic [31:0] ratio_q;
	logic [16:0] alpha_q;

	// Tracking state.
	logic started_q;
	logic [COUNT_BITS-1:0] prev_count_q;
	logic [31:0] prev_time_q;
	logic [2:0] fail_q;
	logic signed [GW-1:0] cont_q;
	logic signed [GW-1:0] start_q;
	logic [WW-1:0] wrapped_q;
	logic signed [31:0] vel_q;

	// Per-item working registers.
	logic [31:0] now_q;
	logic ok_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [31:0] dt_q;
	logic neg_q;
	logic [COUNT_BITS-1:0] mag_q;
	logic [P_W-1:0] p_q;
	logic [M1_W-1:0] m1_q;
	logic [M2_W-1:0] m2_q;
	logic [AW-1:0] ang_q;
	logic [9:0] qe_q;
	logic [AW-1:0] rem_q;
	logic [WW-1:0] wd_q;
	logic [31:0] vhi_q;
	logic [31:0] vlo_q;
	logic [NW-1:0] num_q;
	logic ovf_q;
	logic [31:0] drem_q;
	logic [QW-1:0] quot_q;
	logic signed [31:0] raw_q;
	logic signed [49:0] prod_new_q;
	logic signed [49:0] prod_old_q;
	logic signed [31:0] ema_q;
	logic upd_q;
	logic req_q;

	// Output registers.
	logic out_upd_q;
	logic out_req_q;
	logic [WW-1:0] out_wrap_q;
	logic signed [GW-1:0] out_cent_q;
	logic signed [31:0] out_vel_q;

	logic signed [D_W-1:0] diff;
	logic signed [D_W-1:0] diff_adj;
	logic [31:0] eff_ratio;
	logic [A_W-1:0] a_sum;
	logic [45:0] recip_prod;
	logic [AW-1:0] mod_sub;
	logic [WW-1:0] wr;
	logic [32:0] div_t;
	logic div_ge;
	logic [31:0] qv;
	logic [16:0] a_eff;
	logic [16:0] a_rest;
	logic signed [50:0] s_sum;
	logic [50:0] s_mag;
	logic [50:0] s_rnd;
	logic [31:0] s_r;
	logic signed [AW:0] delta;
	logic signed [GW:0] cont_sum;
	logic signed [GW:0] cent_sum;
	logic [WW:0] wsum;
	logic [2:0] fail_inc;

	always_comb begin
		diff = $signed(D_W'(raw_count)) - $signed(D_W'(prev_count_q));
		if (diff > HALF) begin
			diff_adj = diff - FULL;
		end else if (diff < -HALF) begin
			diff_adj = diff + FULL;
		end else begin
			diff_adj = diff;
		end
		eff_ratio = (ratio_q == '0) ? eavt_pkg::RATIO_ONE : ratio_q;
		a_sum = A_W'(m1_q) + A_W'(m2_q >> 24) + (A_W'(1) << (COUNT_BITS - 1));
		// The turn estimate from the reciprocal is exact or one low, so a single
		// compare and subtract finishes the reduction.
		recip_prod = 46'(ang_q[AW-1:10]) * 46'(eavt_pkg::MOD_RECIP);
		mod_sub = AW'(qe_q) * AW'(eavt_pkg::TWO_PI_Q24);
		wr = (neg_q && rem_q != '0) ? WW'(AW'(eavt_pkg::TWO_PI_Q24) - rem_q) : rem_q[WW-1:0];
		div_t = {drem_q, num_q[cmd.step]};
		div_ge = div_t >= {1'b0, dt_q};
		qv = quot_q[QW-1:8];
		a_eff = (alpha_q > eavt_pkg::ALPHA_ONE) ? eavt_pkg::ALPHA_ONE : alpha_q;
		a_rest = eavt_pkg::ALPHA_ONE - a_eff;
		s_sum = 51'(prod_new_q) + 51'(prod_old_q);
		s_mag = s_sum[50] ? 51'(-s_sum) : s_sum;
		s_rnd = s_mag + 51'd32768;
		s_r = s_rnd[47:16];
		delta = neg_q ? -$signed({1'b0, ang_q}) : $signed({1'b0, ang_q});
		cont_sum = $signed({cont_q[GW-1], cont_q}) + (GW+1)'(delta);
		cent_sum = $signed({cont_q[GW-1], cont_q}) - $signed({start_q[GW-1], start_q});
		wsum = {1'b0, wrapped_q} + {1'b0, wd_q};
		fail_inc = fail_q + 3'd1;
	end

	assign status.started = started_q;
	assign status.read_ok = ok_q;
	assign status.interval_met = dt_q >= {12'd0, interval_q};
	assign status.dt_zero = (dt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= 20'd1000;
			ratio_q <= eavt_pkg::RATIO_ONE;
			alpha_q <= 17'd6554;
		end else if (cfg_we) begin
			case (cfg_index)
				eavt_pkg::CFG_INTERVAL: interval_q <= cfg_data[19:0];
				eavt_pkg::CFG_RATIO: ratio_q <= cfg_data;
				eavt_pkg::CFG_ALPHA: alpha_q <= cfg_data[16:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			prev_count_q <= '0;
			prev_time_q <= '0;
			fail_q <= '0;
			cont_q <= '0;
			start_q <= '0;
			wrapped_q <= '0;
			vel_q <= '0;
		end else begin
			case (cmd.op)
				eavt_pkg::OP_FIRST_OK: begin
					started_q <= 1'b1;
					prev_count_q <= count_q;
					cont_q <= GW'(ang_q);
					start_q <= GW'(ang_q);
					wrapped_q <= wr;
					fail_q <= '0;
					vel_q <= '0;
					prev_time_q <= now_q;
				end
				eavt_pkg::OP_FIRST_FAIL: begin
					started_q <= 1'b1;
					prev_count_q <= '0;
					cont_q <= '0;
					start_q <= '0;
					wrapped_q <= '0;
					fail_q <= 3'd1;
					vel_q <= '0;
					prev_time_q <= now_q;
				end
				eavt_pkg::OP_FAIL: begin
					fail_q <= (fail_inc >= FAIL_LIM) ? 3'd0 : fail_inc;
				end
				eavt_pkg::OP_ZERO_DT: begin
					fail_q <= '0;
					prev_time_q <= now_q;
				end
				eavt_pkg::OP_COMMIT: begin
					fail_q <= '0;
					prev_time_q <= now_q;
					prev_count_q <= count_q;
					vel_q <= ema_q;
					cont_q <= eavt_pkg::sat48(cont_sum);
					wrapped_q <= (wsum >= {1'b0, eavt_pkg::TWO_PI_Q24}) ?
						WW'(wsum - {1'b0, eavt_pkg::TWO_PI_Q24}) : wsum[WW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			eavt_pkg::OP_LOAD: begin
				now_q <= timestamp_us;
				ok_q <= read_ok;
				count_q <= raw_count;
				dt_q <= timestamp_us - prev_time_q;
				upd_q <= 1'b0;
				req_q <= 1'b0;
				if (!started_q) begin
					neg_q <= 1'b0;
					mag_q <= raw_count;
				end else begin
					neg_q <= diff_adj[D_W-1];
					mag_q <= diff_adj[D_W-1] ? COUNT_BITS'(-diff_adj) :
						COUNT_BITS'(diff_adj);
				end
			end
			eavt_pkg::OP_CONV_MUL: p_q <= P_W'(mag_q) * P_W'(eff_ratio);
			eavt_pkg::OP_CONV_HI: m1_q <= M1_W'(p_q[P_W-1:24]) * M1_W'(eavt_pkg::TWO_PI_Q24);
			eavt_pkg::OP_CONV_LO: m2_q <= M2_W'(p_q[23:0]) * M2_W'(eavt_pkg::TWO_PI_Q24);
			eavt_pkg::OP_CONV_SUM: ang_q <= AW'(a_sum >> COUNT_BITS);
			eavt_pkg::OP_MOD_INIT: qe_q <= recip_prod[45:36];
			eavt_pkg::OP_MOD_STEP: begin
				if (cmd.step != '0) begin
					rem_q <= ang_q - mod_sub;
				end else if (rem_q >= AW'(eavt_pkg::TWO_PI_Q24)) begin
					rem_q <= rem_q - AW'(eavt_pkg::TWO_PI_Q24);
				end
			end
			eavt_pkg::OP_FAIL: req_q <= (fail_inc >= FAIL_LIM);
			eavt_pkg::OP_VMUL: begin
				vhi_q <= 32'(ang_q[AW-1:18]) * 32'(eavt_pkg::VEL_SCALE);
				vlo_q <= 32'(ang_q[17:0]) * 32'(eavt_pkg::VEL_SCALE);
				wd_q <= wr;
			end
			eavt_pkg::OP_VSUM: begin
				num_q <= (((NW'(vhi_q) << 18) + NW'(vlo_q)) << 6) + (NW'(dt_q) << 7);
			end
			eavt_pkg::OP_DIV_INIT: begin
				ovf_q <= 32'(num_q[NW-1:QW]) >= dt_q;
				drem_q <= 32'(num_q[NW-1:QW]);
				quot_q <= '0;
			end
			eavt_pkg::OP_DIV_STEP: begin
				drem_q <= div_ge ? 32'(div_t - {1'b0, dt_q}) : div_t[31:0];
				quot_q <= {quot_q[QW-2:0], div_ge};
			end
			eavt_pkg::OP_VSAT: begin
				if (ovf_q) begin
					raw_q <= neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
				end else if (neg_q) begin
					raw_q <= (qv > 32'h8000_0000) ? 32'sh8000_0000 : $signed(32'd0 - qv);
				end else begin
					raw_q <= qv[31] ? 32'sh7FFF_FFFF : $signed(qv);
				end
			end
			eavt_pkg::OP_EMA_NEW: prod_new_q <= $signed({1'b0, a_eff}) * raw_q;
			eavt_pkg::OP_EMA_OLD: prod_old_q <= $signed({1'b0, a_rest}) * vel_q;
			eavt_pkg::OP_EMA_SUM: ema_q <= s_sum[50] ? $signed(32'd0 - s_r) : $signed(s_r);
			eavt_pkg::OP_COMMIT: upd_q <= 1'b1;
			eavt_pkg::OP_OUT: begin
				out_upd_q <= upd_q;
				out_req_q <= req_q;
				out_wrap_q <= wrapped_q;
				out_cent_q <= eavt_pkg::sat48(cent_sum);
				out_vel_q <= vel_q;
			end
			default: begin
			end
		endcase
	end

	assign updated = out_upd_q;
	assign bus_reinit_request = out_req_q;
	assign wrapped_angle = out_wrap_q;
	assign centered_angle = out_cent_q;
	assign velocity = out_vel_q;

endmodule

@@ tb/tb_encoder_angle_velocity_tracker.sv @@
// Self-checking testbench of the encoder angle and velocity tracker.
module tb_encoder_angle_velocity_tracker;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CNT_W = 14;
	localparam int FAIL_LIMIT = 5;
	localparam longint TWO_PI = 105414357;
	localparam longint ANG_HI = 64'sd140737488355327;
	localparam longint ANG_LO = -64'sd140737488355328;
	localparam int CYCLE_LIMIT = 2000000;

	// A result as it leaves the block.
	typedef struct {
		logic upd;
		logic reinit;
		logic [26:0] wrapped;
		logic signed [47:0] centered;
		logic signed [31:0] vel;
	} tracker_result_t;

	// Predicts the tracker and keeps the results still owed by the block.
	class tracker_scoreboard;
		tracker_result_t pending[$];
		int errors;
		longint unsigned interval, ratio, alpha;
		bit started;
		longint prev_count;
		logic [31:0] prev_time;
		int fail_run;
		longint cont, start_ang, wrap_acc;
		longint filt_vel;

		function void clear();
			interval = 1000; ratio = 64'd16777216; alpha = 6554;
			started = 0; prev_count = 0; prev_time = 0; fail_run = 0;
			cont = 0; start_ang = 0; wrap_acc = 0; filt_vel = 0;
			pending.delete(); errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] data);
			case (idx)
				eavt_pkg::CFG_INTERVAL: interval = data[19:0];
				eavt_pkg::CFG_RATIO: ratio = data;
				eavt_pkg::CFG_ALPHA: alpha = data[16:0];
				default: ;
			endcase
		endfunction

		function longint clamp_angle(longint v);
			if (v > ANG_HI) return ANG_HI;
			if (v < ANG_LO) return ANG_LO;
			return v;
		endfunction

		function longint mod_two_pi(longint v);
			longint r;
			r = v % TWO_PI;
			if (r < 0) r += TWO_PI;
			return r;
		endfunction

		// Count difference to wheel angle, rounded half away from zero.
		function longint count_to_angle(longint c);
			longint unsigned r, mag, p, a;
			r = (ratio == 0) ? 64'd16777216 : ratio;
			mag = (c < 0) ? -c : c;
			p = mag * r;
			a = (p >> 24) * TWO_PI + (((p & 64'hFFFFFF) * TWO_PI) >> 24)
				+ (64'd1 << (CNT_W - 1));
			a = a >> CNT_W;
			return (c < 0) ? -longint'(a) : longint'(a);
		endfunction

		function longint speed_from_delta(longint delta, longint unsigned dt);
			longint unsigned mag, d, q;
			mag = (delta < 0) ? -delta : delta;
			d = dt * 256;
			q = (mag * 1000000 + d / 2) / d;
			if (delta < 0) return (q > 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
			return (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
		endfunction

		function longint smooth(longint fresh, longint old);
			longint a, s;
			longint unsigned m;
			a = (alpha > 65536) ? 65536 : alpha;
			s = a * fresh + (65536 - a) * old;
			m = (s < 0) ? -s : s;
			m = (m + 32768) >> 16;
			return (s < 0) ? -longint'(m) : longint'(m);
		endfunction

		// Notes an accepted sample and queues the result it must produce.
		function void note_sample(logic [31:0] ts, logic ok, logic [13:0] cnt);
			tracker_result_t r;
			logic [31:0] dt;
			longint diff, delta;
			r.upd = 0; r.reinit = 0;
			if (!started) begin
				started = 1;
				if (ok) begin
					prev_count = cnt;
					cont = clamp_angle(count_to_angle(cnt));
					start_ang = cont;
					wrap_acc = mod_two_pi(cont);
					fail_run = 0;
				end else begin
					prev_count = 0; cont = 0; start_ang = 0; wrap_acc = 0; fail_run = 1;
				end
				filt_vel = 0;
				prev_time = ts;
			end else begin
				dt = ts - prev_time;
				if (longint'(dt) >= longint'(interval)) begin
					if (!ok) begin
						fail_run++;
						if (fail_run >= FAIL_LIMIT) begin
							r.reinit = 1;
							fail_run = 0;
						end
					end else begin
						fail_run = 0;
						prev_time = ts;
						if (dt != 0) begin
							diff = longint'(cnt) - prev_count;
							if (diff > 8192) diff -= 16384;
							else if (diff < -8192) diff += 16384;
							delta = count_to_angle(diff);
							filt_vel = smooth(speed_from_delta(delta, dt), filt_vel);
							cont = clamp_angle(cont + delta);
							wrap_acc = mod_two_pi(wrap_acc + mod_two_pi(delta));
							prev_count = cnt;
							r.upd = 1;
						end
					end
				end
			end
			r.wrapped = wrap_acc[26:0];
			r.centered = 48'(clamp_angle(cont - start_ang));
			r.vel = filt_vel[31:0];
			pending.push_back(r);
		endfunction

		function void check_result(tracker_result_t got);
			tracker_result_t want;
			if (pending.size() == 0) begin
				$display("%0t: result with none expected: upd %0b", $time, got.upd);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.upd !== want.upd) begin
				$display("%0t: updated exp %0b got %0b", $time, want.upd, got.upd);
				errors++;
			end
			if (got.reinit !== want.reinit) begin
				$display("%0t: reinit exp %0b got %0b", $time, want.reinit, got.reinit);
				errors++;
			end
			if (got.wrapped !== want.wrapped) begin
				$display("%0t: wrapped exp %0d got %0d", $time, want.wrapped, got.wrapped);
				errors++;
			end
			if (got.centered !== want.centered) begin
				$display("%0t: centered exp %0d got %0d", $time, want.centered, got.centered);
				errors++;
			end
			if (got.vel !== want.vel) begin
				$display("%0t: velocity exp %0d got %0d", $time, want.vel, got.vel);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_ready;
	logic [31:0] timestamp_us = '0;
	logic read_ok = 0;
	logic [13:0] raw_count = '0;
	logic out_valid;
	logic out_ready = 0;
	logic updated, bus_reinit_request;
	logic [26:0] wrapped_angle;
	logic signed [47:0] centered_angle;
	logic signed [31:0] velocity;

	tracker_scoreboard sb = new();
	int cycles = 0;
	bit stim_done = 0;
	// Set while the receiver must hold off for a long stretch.
	bit hold_sink = 0;
	// Time base that the sample timestamps advance from.
	logic [31:0] clock_us = 0;

	encoder_angle_velocity_tracker u_dut (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.in_valid, .in_ready, .timestamp_us, .read_ok, .raw_count,
		.out_valid, .out_ready, .updated, .bus_reinit_request,
		.wrapped_angle, .centered_angle, .velocity
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// A run that goes past this count of cycles is stopped and reported as mismatches.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Writes one configuration register; the block must be idle.
	task automatic write_reg(logic [1:0] idx, logic [31:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	// Offers one sample after a random gap, unless no_gap is set, and returns once it is taken.
	// Valid stays high after the handshake until the next gap or a drain drops it.
	task automatic send_sample(logic [31:0] ts, logic ok, logic [13:0] cnt, bit no_gap = 0);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		timestamp_us <= ts;
		read_ok <= ok;
		raw_count <= cnt;
		do @(posedge clk); while (!in_ready);
		sb.note_sample(ts, ok, cnt);
	endtask

	// Stops offering, waits until every result has come, then lets the longest latency pass.
	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	// Next timestamp: mostly past the interval, sometimes too early or far off.
	function automatic logic [31:0] next_time();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 6) clock_us = 32'(clock_us + sb.interval + $urandom_range(0, 3000));
		else if (pick < 8) clock_us = clock_us + $urandom_range(0, 1200);
		else clock_us = clock_us + $urandom;
		return clock_us;
	endfunction

	// Count change: mostly small motion, sometimes any value.
	function automatic logic [13:0] next_count(logic [13:0] cur);
		if ($urandom_range(0, 3) == 0) return 14'($urandom);
		return cur + 14'($signed($urandom_range(0, 800)) - 400);
	endfunction

	// Result side: random stalls, plus the long hold-off when asked.
	initial begin
		tracker_result_t got;
		int wait_cycles;
		@(posedge arst_n);
		forever begin
			wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
			if (wait_cycles > 0 || hold_sink) begin
				out_ready <= 0;
				repeat (wait_cycles) @(posedge clk);
				while (hold_sink) @(posedge clk);
			end
			out_ready <= 1;
			do @(posedge clk); while (!out_valid);
			got.upd = updated;
			got.reinit = bus_reinit_request;
			got.wrapped = wrapped_angle;
			got.centered = centered_angle;
			got.vel = velocity;
			sb.check_result(got);
		end
	end

	initial begin
		logic [13:0] cnt;
		int phase;
		sb.clear();
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed part: failed first read, then failures up to a reinit request.
		send_sample(32'd500, 0, 14'd123);
		send_sample(32'd600, 1, 14'd5);
		send_sample(32'd2000, 0, 14'd0);
		send_sample(32'd3000, 0, 14'd0);
		send_sample(32'd4000, 0, 14'd0);
		send_sample(32'd5000, 0, 14'd0);
		send_sample(32'd6000, 1, 14'd8192);
		// Exactly plus and minus half a turn, full count extremes, timestamp wrap.
		send_sample(32'd7000, 1, 14'd0);
		send_sample(32'd8000, 1, 14'd8192);
		send_sample(32'd9000, 1, 14'd16383);
		send_sample(32'hFFFF_FF00, 1, 14'd1);
		send_sample(32'h0000_0400, 1, 14'd16383);
		drain();
		// Zero interval allows zero elapsed time; extreme ratio, alpha above one.
		write_reg(eavt_pkg::CFG_INTERVAL, 32'd0);
		write_reg(eavt_pkg::CFG_RATIO, 32'hFFFF_FFFF);
		write_reg(eavt_pkg::CFG_ALPHA, 32'h1FFFF);
		send_sample(32'h0000_0400, 1, 14'd100);
		send_sample(32'h0000_0401, 1, 14'd8292);
		send_sample(32'h0000_0402, 1, 14'd100);
		send_sample(32'h0000_0402, 0, 14'd9);
		send_sample(32'h0000_0403, 1, 14'd16383);
		drain();
		write_reg(eavt_pkg::CFG_RATIO, 32'd0);
		write_reg(eavt_pkg::CFG_ALPHA, 32'd0);
		write_reg(eavt_pkg::CFG_INTERVAL, 32'hFFFFF);
		send_sample(32'h0010_0500, 1, 14'd50);
		send_sample(32'h0020_0600, 1, 14'd8000);
		drain();

		clock_us = 32'h0020_0600;
		cnt = 14'd8000;
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					write_reg(eavt_pkg::CFG_INTERVAL, 32'd1000);
					write_reg(eavt_pkg::CFG_RATIO, 32'h0100_0000);
					write_reg(eavt_pkg::CFG_ALPHA, 32'd6554);
				end
				1: begin
					write_reg(eavt_pkg::CFG_INTERVAL, 32'd1);
					write_reg(eavt_pkg::CFG_RATIO, $urandom);
					write_reg(eavt_pkg::CFG_ALPHA, 32'h10000);
				end
				2: begin
					write_reg(eavt_pkg::CFG_INTERVAL, $urandom_range(0, 4000));
					write_reg(eavt_pkg::CFG_RATIO, 32'hFFFF_FFFF);
					write_reg(eavt_pkg::CFG_ALPHA, $urandom_range(0, 131071));
				end
				3: begin
					write_reg(eavt_pkg::CFG_INTERVAL, 32'd0);
					write_reg(eavt_pkg::CFG_RATIO, 32'h0000_0001);
					write_reg(eavt_pkg::CFG_ALPHA, 32'd0);
				end
				4: begin
					write_reg(eavt_pkg::CFG_INTERVAL, 32'd1000000);
					write_reg(eavt_pkg::CFG_RATIO, 32'h0800_0000);
					write_reg(eavt_pkg::CFG_ALPHA, 32'd30000);
				end
				default: begin
					write_reg(eavt_pkg::CFG_INTERVAL, $urandom_range(1, 2000));
					write_reg(eavt_pkg::CFG_RATIO, $urandom);
					write_reg(eavt_pkg::CFG_ALPHA, $urandom_range(0, 65536));
				end
			endcase
			// In one phase the receiver stalls long while samples keep coming.
			if (phase == 2) begin
				fork
					begin
						hold_sink = 1;
						repeat (400) @(posedge clk);
						hold_sink = 0;
					end
				join_none
			end
			repeat (150) begin
				cnt = next_count(cnt);
				send_sample(next_time(), $urandom_range(0, 7) != 0, cnt, phase == 2);
			end
			// The sender pauses here until every result has arrived.
			drain();
		end
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
